// ----- rtl/msgpack_stream_tokenizer_top_macros.svh -----
// Assertion helpers shared by the tokenizer modules.
`ifndef MSGPACK_STREAM_TOKENIZER_TOP_MACROS_SVH
`define MSGPACK_STREAM_TOKENIZER_TOP_MACROS_SVH

// Clocked check, off while reset is asserted.
`define MSGST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("msgst check failed");

// Same, with a caller supplied message.
`define MSGST_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ----- rtl/msgst_pkg.sv -----
package msgst_pkg;

  typedef enum logic [3:0] {
    K_NIL     = 4'd0,
    K_FALSE   = 4'd1,
    K_TRUE    = 4'd2,
    K_UINT    = 4'd3,
    K_INT     = 4'd4,
    K_F32     = 4'd5,
    K_F64     = 4'd6,
    K_STR     = 4'd7,
    K_BIN     = 4'd8,
    K_ARRAY   = 4'd9,
    K_MAP     = 4'd10,
    K_PAYLOAD = 4'd11,
    K_ERROR   = 4'd12
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TYPE     = 2'd1,
    ERR_KEY      = 2'd2,
    ERR_DEPTH    = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_FIELD   = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    S_IN   = 3'd0,
    S_DEC  = 3'd1,
    S_FIN  = 3'd2,
    S_LOAD = 3'd3,
    S_EMIT = 3'd4
  } state_e;

  // Stack entry: remaining items (a map counts keys and values) and map flag.
  typedef struct packed {
    logic [32:0] cnt;
    logic        map;
  } entry_t;

  typedef struct packed {
    logic cap;
    logic dec;
    logic fin;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic dec_fin;
    logic dec_emit;
    logic fin_more;
    logic out_free;
  } stat_t;

  localparam logic [7:0] B_POSFIX_MAX = 8'h7F;
  localparam logic [7:0] B_NEGFIX_MIN = 8'hE0;
  localparam logic [7:0] B_FIXMAP_MAX = 8'h8F;
  localparam logic [7:0] B_FIXARR_MIN = 8'h90;
  localparam logic [7:0] B_FIXARR_MAX = 8'h9F;
  localparam logic [7:0] B_FIXSTR_MIN = 8'hA0;
  localparam logic [7:0] B_FIXSTR_MAX = 8'hBF;
  localparam logic [7:0] B_NIL        = 8'hC0;
  localparam logic [7:0] B_NEVER      = 8'hC1;
  localparam logic [7:0] B_FALSE      = 8'hC2;
  localparam logic [7:0] B_TRUE       = 8'hC3;
  localparam logic [7:0] B_BIN8       = 8'hC4;
  localparam logic [7:0] B_BIN32      = 8'hC6;
  localparam logic [7:0] B_EXT8       = 8'hC7;
  localparam logic [7:0] B_EXT32      = 8'hC9;
  localparam logic [7:0] B_F32        = 8'hCA;
  localparam logic [7:0] B_F64        = 8'hCB;
  localparam logic [7:0] B_UINT8      = 8'hCC;
  localparam logic [7:0] B_UINT64     = 8'hCF;
  localparam logic [7:0] B_INT8       = 8'hD0;
  localparam logic [7:0] B_INT64      = 8'hD3;
  localparam logic [7:0] B_FIXEXT1    = 8'hD4;
  localparam logic [7:0] B_FIXEXT16   = 8'hD8;
  localparam logic [7:0] B_STR8       = 8'hD9;
  localparam logic [7:0] B_STR32      = 8'hDB;
  localparam logic [7:0] B_ARR16      = 8'hDC;
  localparam logic [7:0] B_ARR32      = 8'hDD;
  localparam logic [7:0] B_MAP16      = 8'hDE;

endpackage

// ----- rtl/msgst_ram.sv -----
module msgst_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/msgst_ctrl.sv -----
`include "msgpack_stream_tokenizer_top_macros.svh"

module msgst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  msgst_pkg::stat_t st_i,
  output msgst_pkg::cmd_t  cmd_o
);
  import msgst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IN: begin
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        if (st_i.dec_fin) state_d = S_FIN;
        else if (st_i.dec_emit) state_d = S_EMIT;
        else state_d = S_IN;
      end
      S_FIN: begin
        state_d = st_i.fin_more ? S_LOAD : S_EMIT;
      end
      S_LOAD: state_d = S_FIN;
      S_EMIT: begin
        if (st_i.out_free) state_d = S_IN;
      end
      default: state_d = S_IN;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IN: begin
        in_stall_o = 1'b0;
        cmd_o.cap  = in_valid_i;
      end
      S_DEC:  cmd_o.dec  = 1'b1;
      S_FIN:  cmd_o.fin  = 1'b1;
      S_LOAD: cmd_o.load = 1'b1;
      S_EMIT: cmd_o.emit = st_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  `MSGST_ASSERT(a_load_then_fin, (state_q == S_LOAD) |=> (state_q == S_FIN))
  `MSGST_ASSERT_MSG(a_emit_free, cmd_o.emit |-> st_i.out_free, "emit into busy output")
endmodule

// ----- rtl/msgst_dp.sv -----
`include "msgpack_stream_tokenizer_top_macros.svh"

module msgst_dp #(
  parameter int MAX_NESTING = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msgst_pkg::cmd_t  cmd_i,
  output msgst_pkg::stat_t st_o,
  input  logic [7:0]       stream_byte_i,
  input  logic             cfg_valid_i,
  input  logic [4:0]       cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [3:0]       token_kind_o,
  output logic [63:0]      token_value_o,
  output logic [4:0]       nesting_depth_o,
  output logic             is_map_key_o,
  output logic             value_complete_o,
  output logic [1:0]       error_code_o
);
  import msgst_pkg::*;

  localparam int SPW = $clog2(MAX_NESTING + 1);
  localparam int AW  = $clog2(MAX_NESTING);
  localparam int CW  = (SPW > 5) ? SPW + 1 : 6;

  logic [7:0]     byte_q;
  phase_e         phase_q, phase_d;
  logic [3:0]     left_q, left_d;
  logic [3:0]     fw_q, fw_d;
  logic [63:0]    acc_q, acc_d;
  kind_e          pk_q, pk_d;
  logic [31:0]    pl_q, pl_d;
  logic [SPW-1:0] sp_q, sp_d;
  entry_t         top_q, top_d;
  err_e           err_q, err_d;
  logic [4:0]     maxd_q;

  kind_e          tk_q, tk_d;
  logic [63:0]    tv_q, tv_d;
  logic [4:0]     tdep_q, tdep_d;
  logic           tkey_q, tkey_d;
  logic           tdone_q, tdone_d;
  err_e           terr_q, terr_d;

  logic           ov_q, ov_d;
  kind_e          ok_q;
  logic [63:0]    ovl_q;
  logic [4:0]     odep_q;
  logic           okey_q, odone_q;
  err_e           oerr_q;

  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  entry_t         rdata;

  logic           key_due, is_str, is_cont, bad_type, too_deep;
  logic           hdr_go, scl_go;
  kind_e          hk, sk;
  logic [31:0]    hl;
  logic [63:0]    sv, acc_n;
  logic [3:0]     left_n;
  logic [31:0]    pl_n;
  logic [32:0]    rem;
  logic [7:0]     b;

  assign b       = byte_q;
  assign key_due = (sp_q != '0) && top_q.map && !top_q.cnt[0];
  assign is_str  = (b >= B_FIXSTR_MIN && b <= B_FIXSTR_MAX) || (b >= B_STR8 && b <= B_STR32);
  assign is_cont = (b > B_POSFIX_MAX && b <= B_FIXARR_MAX) || (b >= B_ARR16 && b < B_NEGFIX_MIN);
  assign bad_type = (b == B_NEVER) || (b >= B_EXT8 && b <= B_EXT32)
                 || (b >= B_FIXEXT1 && b <= B_FIXEXT16);
  assign too_deep = (CW'(sp_q) >= CW'(maxd_q)) || (CW'(sp_q) >= CW'(MAX_NESTING));
  assign rem      = top_q.cnt - 33'd1;

  always_comb begin
    phase_d = phase_q; left_d = left_q; fw_d = fw_q; acc_d = acc_q; pk_d = pk_q;
    pl_d = pl_q; sp_d = sp_q; top_d = top_q; err_d = err_q;
    tk_d = tk_q; tv_d = tv_q; tdep_d = tdep_q; tkey_d = tkey_q;
    tdone_d = tdone_q; terr_d = terr_q;
    st_o = '0;
    we = 1'b0; re = 1'b0;
    waddr = AW'(sp_q - SPW'(1));
    raddr = AW'(sp_q - SPW'(2));
    hdr_go = 1'b0; scl_go = 1'b0;
    hk = K_ARRAY; hl = '0; sk = K_NIL; sv = '0;
    acc_n = {acc_q[55:0], b};
    left_n = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
    pl_n = (pl_q != 32'd0) ? pl_q - 32'd1 : 32'd0;

    if (cmd_i.dec && err_q == ERR_NONE) begin
      case (phase_q)
        PH_FIELD: begin
          acc_d  = acc_n;
          left_d = left_n;
          if (left_n == 4'd0) begin
            phase_d = PH_TYPE;
            if (pk_q >= K_STR) begin
              hdr_go = 1'b1; hk = pk_q; hl = acc_n[31:0];
            end else begin
              scl_go = 1'b1; sk = pk_q; sv = acc_n;
              if (pk_q == K_INT) begin
                case (fw_q)
                  4'd1: sv = {{56{acc_n[7]}}, acc_n[7:0]};
                  4'd2: sv = {{48{acc_n[15]}}, acc_n[15:0]};
                  4'd4: sv = {{32{acc_n[31]}}, acc_n[31:0]};
                  default: sv = acc_n;
                endcase
              end
            end
          end
        end
        PH_PAYLOAD: begin
          pl_d = pl_n;
          tk_d = K_PAYLOAD; tv_d = {56'd0, b}; tdep_d = 5'(sp_q);
          tkey_d = 1'b0; tdone_d = 1'b0; terr_d = ERR_NONE;
          st_o.dec_emit = 1'b1;
          if (pl_n == 32'd0) begin
            phase_d = PH_TYPE;
            st_o.dec_fin = 1'b1;
          end
        end
        default: begin
          phase_d = PH_TYPE;
          if (bad_type || (key_due && !is_str) || (is_cont && too_deep)) begin
            err_d = bad_type ? ERR_TYPE : ((key_due && !is_str) ? ERR_KEY : ERR_DEPTH);
            tk_d = K_ERROR; tv_d = {56'd0, b}; tdep_d = 5'(sp_q);
            tkey_d = 1'b0; tdone_d = 1'b0; terr_d = err_d;
            st_o.dec_emit = 1'b1;
          end else if (b <= B_POSFIX_MAX) begin
            scl_go = 1'b1; sk = K_UINT; sv = {56'd0, b};
          end else if (b >= B_NEGFIX_MIN) begin
            scl_go = 1'b1; sk = K_INT; sv = {56'hFF_FFFF_FFFF_FFFF, b};
          end else if (b <= B_FIXMAP_MAX) begin
            hdr_go = 1'b1; hk = K_MAP; hl = {28'd0, b[3:0]};
          end else if (b <= B_FIXARR_MAX) begin
            hdr_go = 1'b1; hk = K_ARRAY; hl = {28'd0, b[3:0]};
          end else if (b <= B_FIXSTR_MAX) begin
            hdr_go = 1'b1; hk = K_STR; hl = {27'd0, b[4:0]};
          end else if (b == B_NIL) begin
            scl_go = 1'b1; sk = K_NIL; sv = 64'd0;
          end else if (b == B_FALSE) begin
            scl_go = 1'b1; sk = K_FALSE; sv = 64'd0;
          end else if (b == B_TRUE) begin
            scl_go = 1'b1; sk = K_TRUE; sv = 64'd1;
          end else begin
            // Multi-byte field follows; remember its kind and width.
            phase_d = PH_FIELD;
            acc_d   = '0;
            if (b <= B_BIN32) begin
              pk_d = K_BIN; fw_d = 4'd1 << b[1:0];
            end else if (b == B_F32) begin
              pk_d = K_F32; fw_d = 4'd4;
            end else if (b == B_F64) begin
              pk_d = K_F64; fw_d = 4'd8;
            end else if (b <= B_UINT64) begin
              pk_d = K_UINT; fw_d = 4'd1 << b[1:0];
            end else if (b <= B_INT64) begin
              pk_d = K_INT; fw_d = 4'd1 << b[1:0];
            end else if (b <= B_STR32) begin
              pk_d = K_STR; fw_d = 4'd1 << 2'(b[1:0] - 2'd1);
            end else if (b <= B_ARR32) begin
              pk_d = K_ARRAY; fw_d = 4'd2 << b[0];
            end else begin
              pk_d = K_MAP; fw_d = 4'd2 << b[0];
            end
            left_d = fw_d;
          end
        end
      endcase

      if (scl_go) begin
        tk_d = sk; tv_d = sv; tdep_d = 5'(sp_q); tkey_d = key_due;
        tdone_d = 1'b0; terr_d = ERR_NONE;
        st_o.dec_emit = 1'b1;
        st_o.dec_fin  = 1'b1;
      end
      if (hdr_go) begin
        tk_d = hk; tv_d = {32'd0, hl}; tdep_d = 5'(sp_q); tkey_d = key_due;
        tdone_d = 1'b0; terr_d = ERR_NONE;
        st_o.dec_emit = 1'b1;
        if (hl == 32'd0) begin
          st_o.dec_fin = 1'b1;
        end else if (hk == K_STR || hk == K_BIN) begin
          pl_d = hl; phase_d = PH_PAYLOAD;
        end else if (CW'(sp_q) < CW'(MAX_NESTING)) begin
          we = (sp_q != '0);
          top_d.map = (hk == K_MAP);
          top_d.cnt = (hk == K_MAP) ? {hl, 1'b0} : {1'b0, hl};
          sp_d = sp_q + SPW'(1);
        end
      end
    end

    // One step per FIN cycle; a pop to an open entry reloads from stack memory.
    if (cmd_i.fin) begin
      if (sp_q == '0) begin
        tdone_d = 1'b1;
      end else if (rem != 33'd0) begin
        top_d.cnt = rem;
      end else begin
        sp_d = sp_q - SPW'(1);
        if (sp_q == SPW'(1)) begin
          tdone_d = 1'b1;
        end else begin
          re = 1'b1;
          st_o.fin_more = 1'b1;
        end
      end
    end

    if (cmd_i.load) begin
      top_d = rdata;
    end

    st_o.out_free = !ov_q || !out_stall_i;
    ov_d = ov_q;
    if (cmd_i.emit) ov_d = 1'b1;
    else if (!out_stall_i) ov_d = 1'b0;
  end

  msgst_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_NESTING)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(top_q),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      left_q  <= '0;
      sp_q    <= '0;
      err_q   <= ERR_NONE;
      maxd_q  <= 5'd16;
      ov_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      sp_q    <= sp_d;
      err_q   <= err_d;
      ov_q    <= ov_d;
      if (cfg_valid_i) maxd_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) byte_q <= stream_byte_i;
    fw_q    <= fw_d;
    acc_q   <= acc_d;
    pk_q    <= pk_d;
    pl_q    <= pl_d;
    top_q   <= top_d;
    tk_q    <= tk_d;
    tv_q    <= tv_d;
    tdep_q  <= tdep_d;
    tkey_q  <= tkey_d;
    tdone_q <= tdone_d;
    terr_q  <= terr_d;
    if (cmd_i.emit) begin
      ok_q    <= tk_q;
      ovl_q   <= tv_q;
      odep_q  <= tdep_q;
      okey_q  <= tkey_q;
      odone_q <= tdone_q;
      oerr_q  <= terr_q;
    end
  end

  assign out_valid_o      = ov_q;
  assign token_kind_o     = ok_q;
  assign token_value_o    = ovl_q;
  assign nesting_depth_o  = odep_q;
  assign is_map_key_o     = okey_q;
  assign value_complete_o = odone_q;
  assign error_code_o     = oerr_q;

  `MSGST_ASSERT(a_err_sticky, (err_q != ERR_NONE) |=> (err_q == $past(err_q)))
  `MSGST_ASSERT(a_sp_bound, CW'(sp_q) <= CW'(MAX_NESTING))
  `MSGST_ASSERT_MSG(a_emit_valid, cmd_i.emit |=> ov_q, "emitted token not presented")
endmodule

// ----- rtl/msgpack_stream_tokenizer_top.sv -----
// MessagePack stream tokenizer.
// Input channel: in_valid_i / in_stall_o with stream_byte_i; one byte moves
// per transfer. Output channel: out_valid_o / out_stall_i with one token per
// transfer (kind, value, nesting depth, map-key flag, value-complete flag,
// error code). A byte yields zero or one token.
// Config: cfg_valid_i / cfg_ready_o writes max_depth; ready is always high.
// Write it only while no byte is in flight.
// Timing: a byte is taken, decoded in the next cycle, and its token is loaded
// into the output register in the emit state once that register is free; a
// byte that gives no token skips the emit state. A token that finishes an item
// (a scalar, the last payload byte, an empty string or container) first takes
// a count step that counts the item against the enclosing container. Each
// container that closes with another still open beneath it adds a reload of
// the new top entry from the stack memory (registered read port).
// The output register frees the decoder: the next byte is taken while a
// token waits on a stalled receiver; a second token then waits for it.
// Reset clears the parser, the stack pointer and any latched error; stack
// memory contents need no clearing. After an error token all further bytes
// are consumed silently until reset.
module msgpack_stream_tokenizer_top #(
  parameter int MAX_NESTING = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [63:0] token_value_o,
  output logic [4:0]  nesting_depth_o,
  output logic        is_map_key_o,
  output logic        value_complete_o,
  output logic [1:0]  error_code_o
);
  import msgst_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready_o = 1'b1;

  msgst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  msgst_dp #(
    .MAX_NESTING(MAX_NESTING)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .stream_byte_i   (stream_byte_i),
    .cfg_valid_i     (cfg_valid_i & cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .token_kind_o    (token_kind_o),
    .token_value_o   (token_value_o),
    .nesting_depth_o (nesting_depth_o),
    .is_map_key_o    (is_map_key_o),
    .value_complete_o(value_complete_o),
    .error_code_o    (error_code_o)
  );
endmodule

// ----- dv/msgpack_stream_tokenizer_top_test.sv -----
`timescale 1ns / 1ps

module msgpack_stream_tokenizer_top_test;
  import msgst_pkg::*;

  localparam int NEST = 16;
  localparam int SETTLE = 60;

  typedef struct {
    kind_e       kind;
    logic [63:0] value;
    logic [4:0]  depth;
    logic        key;
    logic        done;
    err_e        code;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  stream_byte_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  token_kind_o;
  logic [63:0] token_value_o;
  logic [4:0]  nesting_depth_o;
  logic        is_map_key_o;
  logic        value_complete_o;
  logic [1:0]  error_code_o;

  msgpack_stream_tokenizer_top #(.MAX_NESTING(NEST)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tokenizer state mirror
  phase_e      phase;
  int unsigned field_left;
  logic [63:0] field_acc;
  kind_e       field_kind;
  logic [31:0] bytes_left;
  logic [33:0] ctr_stack [NEST];
  int unsigned depth_ptr;
  logic [1:0]  err_held;
  logic [4:0]  depth_limit;

  token_t      token_q[$];
  logic [7:0]  byte_q[$];
  int          failures = 0;
  bit          steady = 1'b0;

  function automatic bit key_due();
    return depth_ptr > 0 && ctr_stack[depth_ptr-1][0] && !ctr_stack[depth_ptr-1][1];
  endfunction

  function automatic bit close_items();
    logic [32:0] rem;
    while (depth_ptr > 0) begin
      rem = ctr_stack[depth_ptr-1][33:1] - 33'd1;
      if (rem != 0) begin
        ctr_stack[depth_ptr-1][33:1] = rem;
        return 1'b0;
      end
      depth_ptr--;
    end
    return 1'b1;
  endfunction

  function automatic token_t scalar_tok(kind_e k, logic [63:0] v);
    token_t t;
    t.kind = k; t.value = v; t.depth = depth_ptr[4:0]; t.key = key_due();
    t.done = close_items(); t.code = ERR_NONE;
    return t;
  endfunction

  function automatic token_t header_tok(kind_e k, logic [31:0] len);
    token_t t;
    t.kind = k; t.value = {32'd0, len}; t.depth = depth_ptr[4:0]; t.key = key_due();
    t.done = 1'b0; t.code = ERR_NONE;
    phase = PH_TYPE;
    if (len == 0) t.done = close_items();
    else if (k == K_STR || k == K_BIN) begin
      bytes_left = len;
      phase = PH_PAYLOAD;
    end else if (depth_ptr < NEST) begin
      ctr_stack[depth_ptr] = {(k == K_MAP) ? {len, 1'b0} : {1'b0, len}, k == K_MAP};
      depth_ptr++;
    end
    return t;
  endfunction

  function automatic token_t error_tok(err_e c, logic [7:0] b);
    token_t t;
    err_held = c;
    t.kind = K_ERROR; t.value = {56'd0, b}; t.depth = depth_ptr[4:0];
    t.key = 1'b0; t.done = 1'b0; t.code = c;
    return t;
  endfunction

  function automatic void open_field(kind_e k, int unsigned n);
    phase = PH_FIELD; field_kind = k; field_left = n; bytes_left = n; field_acc = '0;
  endfunction

  function automatic bit tokenize(logic [7:0] b, output token_t t);
    int unsigned lim;
    bit is_str, is_cont;
    if (err_held != 0) return 1'b0;
    if (phase == PH_FIELD) begin
      field_acc = {field_acc[55:0], b};
      if (field_left > 0) field_left--;
      if (field_left != 0) return 1'b0;
      phase = PH_TYPE;
      if (field_kind >= K_STR) begin
        t = header_tok(field_kind, field_acc[31:0]);
        return 1'b1;
      end
      if (field_kind == K_INT && bytes_left >= 1 && bytes_left < 8)
        if (field_acc[bytes_left*8-1]) field_acc = field_acc | (~64'd0 << (bytes_left*8));
      t = scalar_tok(field_kind, field_acc);
      return 1'b1;
    end
    if (phase == PH_PAYLOAD) begin
      t.kind = K_PAYLOAD; t.value = {56'd0, b}; t.depth = depth_ptr[4:0];
      t.key = 1'b0; t.done = 1'b0; t.code = ERR_NONE;
      if (bytes_left > 0) bytes_left--;
      if (bytes_left == 0) begin
        phase = PH_TYPE;
        t.done = close_items();
      end
      return 1'b1;
    end
    lim = depth_limit < NEST ? depth_limit : NEST;
    is_str = (b >= B_FIXSTR_MIN && b <= B_FIXSTR_MAX) || (b >= B_STR8 && b <= B_STR32);
    is_cont = (b >= 8'h80 && b <= B_FIXARR_MAX) || b >= B_ARR16 && b <= 8'hDF;
    if (b == B_NEVER || (b >= B_EXT8 && b <= B_EXT32) || (b >= B_FIXEXT1 && b <= B_FIXEXT16))
      t = error_tok(ERR_TYPE, b);
    else if (key_due() && !is_str) t = error_tok(ERR_KEY, b);
    else if (is_cont && depth_ptr >= lim) t = error_tok(ERR_DEPTH, b);
    else if (b <= B_POSFIX_MAX) t = scalar_tok(K_UINT, {56'd0, b});
    else if (b >= B_NEGFIX_MIN) t = scalar_tok(K_INT, {{56{1'b1}}, b});
    else if (b <= B_FIXMAP_MAX) t = header_tok(K_MAP, {28'd0, b[3:0]});
    else if (b <= B_FIXARR_MAX) t = header_tok(K_ARRAY, {28'd0, b[3:0]});
    else if (b <= B_FIXSTR_MAX) t = header_tok(K_STR, {27'd0, b[4:0]});
    else if (b == B_NIL) t = scalar_tok(K_NIL, 64'd0);
    else if (b == B_FALSE) t = scalar_tok(K_FALSE, 64'd0);
    else if (b == B_TRUE) t = scalar_tok(K_TRUE, 64'd1);
    else begin
      if (b <= B_BIN32) open_field(K_BIN, 1 << (b - B_BIN8));
      else if (b == B_F32) open_field(K_F32, 4);
      else if (b == B_F64) open_field(K_F64, 8);
      else if (b <= B_UINT64) open_field(K_UINT, 1 << (b - B_UINT8));
      else if (b <= B_INT64) open_field(K_INT, 1 << (b - B_INT8));
      else if (b <= B_STR32) open_field(K_STR, 1 << (b - B_STR8));
      else if (b <= B_ARR32) open_field(K_ARRAY, 2 << (b - B_ARR16));
      else open_field(K_MAP, 2 << (b - B_MAP16));
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------- stimulus helpers

  task automatic send_byte(logic [7:0] b);
    int gap;
    token_t t;
    gap = steady ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (tokenize(b, t)) token_q.push_back(t);
  endtask

  task automatic flush_bytes();
    while (byte_q.size() > 0) send_byte(byte_q.pop_front());
  endtask

  task automatic drain();
    int guard;
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    guard = 0;
    while (token_q.size() > 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_depth(logic [4:0] d);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    depth_limit = d;
  endtask

  function automatic void put_be(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) byte_q.push_back(v[i*8 +: 8]);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void put_str(bit bin, int len);
    int form;
    form = $urandom_range(0, 3);
    if (bin) begin
      byte_q.push_back(B_BIN8 + form % 3);
      put_be(len, 1 << (form % 3));
    end else if (form == 0) byte_q.push_back(B_FIXSTR_MIN | len[4:0]);
    else begin
      byte_q.push_back(B_STR8 + form - 1);
      put_be(len, 1 << (form - 1));
    end
    repeat (len) byte_q.push_back($urandom_range(0, 255));
  endfunction

  // well-formed value with random content; nd = containers already open
  function automatic void build_value(int nd);
    int sel, n, w, lim;
    lim = depth_limit < NEST ? depth_limit : NEST;
    sel = $urandom_range(0, (nd < lim && nd < 5) ? 9 : 6);
    case (sel)
      0: byte_q.push_back($urandom_range(0, 255) & 8'h7F);
      1: byte_q.push_back($urandom_range(8'hE0, 8'hFF));
      2: byte_q.push_back($urandom_range(0, 2) == 0 ? B_NIL : B_FALSE + $urandom_range(0, 1));
      3: begin
        w = $urandom_range(0, 3);
        byte_q.push_back(($urandom_range(0, 1) ? B_UINT8 : B_INT8) + w);
        put_be(rnd64(), 1 << w);
      end
      4: begin
        w = $urandom_range(0, 1);
        byte_q.push_back(B_F32 + w);
        put_be(rnd64(), w ? 8 : 4);
      end
      5, 6: put_str(sel == 6, $urandom_range(0, 4));
      default: begin
        n = $urandom_range(0, 3);
        w = $urandom_range(0, 2);
        if (sel == 9) begin
          if (w == 0) byte_q.push_back(8'h80 | n[3:0]);
          else begin byte_q.push_back(B_MAP16 + w - 1); put_be(n, 2 * w); end
          repeat (n) begin
            put_str(1'b0, $urandom_range(0, 3));
            build_value(nd + 1);
          end
        end else begin
          if (w == 0) byte_q.push_back(B_FIXARR_MIN | n[3:0]);
          else begin byte_q.push_back(B_ARR16 + w - 1); put_be(n, 2 * w); end
          repeat (n) build_value(nd + 1);
        end
      end
    endcase
  endfunction

  task automatic run_values(int nbytes);
    int sent;
    sent = 0;
    while (sent < nbytes) begin
      if ($urandom_range(0, 15) == 0) steady = ~steady;
      build_value(0);
      sent += byte_q.size();
      flush_bytes();
    end
    steady = 1'b0;
  endtask

  // ---------------- tests

  task automatic test_directed();
    byte_q = '{8'h00, 8'h7F, 8'hE0, 8'hFF, B_NIL, B_FALSE, B_TRUE};
    byte_q.push_back(B_F32); put_be(64'h8000_0001, 4);
    byte_q.push_back(B_F64); put_be(64'hFFFF_FFFF_FFFF_FFFF, 8);
    for (int w = 0; w < 4; w++) begin
      byte_q.push_back(B_UINT8 + w); put_be(~64'd0, 1 << w);
      byte_q.push_back(B_INT8 + w); put_be(64'h8080_8080_8080_8080, 1 << w);
      byte_q.push_back(B_INT8 + w); put_be(64'h7F7F_7F7F_7F7F_7F7F, 1 << w);
    end
    byte_q.push_back(B_FIXSTR_MIN);
    byte_q.push_back(B_STR32); put_be(2, 4); byte_q.push_back(8'hFF); byte_q.push_back(8'h00);
    byte_q.push_back(B_BIN8); put_be(0, 1);
    byte_q.push_back(B_BIN32); put_be(1, 4); byte_q.push_back(8'hA5);
    byte_q.push_back(B_FIXARR_MIN);
    byte_q.push_back(B_ARR32); put_be(0, 4);
    byte_q.push_back(B_MAP16 + 1); put_be(0, 4);
    // map key then nested containers closing together
    byte_q.push_back(8'h81); byte_q.push_back(8'hA1); byte_q.push_back(8'h6B);
    byte_q.push_back(8'h91); byte_q.push_back(B_ARR16); put_be(1, 2);
    byte_q.push_back(B_MAP16); put_be(1, 2); byte_q.push_back(8'hA0); byte_q.push_back(8'h01);
    flush_bytes();
  endtask

  task automatic test_random_values();
    run_values(900);
  endtask

  task automatic test_depth_settings();
    write_depth(5'd1);
    run_values(200);
    write_depth(5'd31);
    run_values(200);
    write_depth(5'd3);
    run_values(150);
    write_depth(5'd16);
    // nest to the full limit
    repeat (16) byte_q.push_back(8'h91);
    byte_q.push_back(B_NIL);
    flush_bytes();
  endtask

  task automatic test_pause();
    run_values(100);
    drain();
    run_values(100);
  endtask

  // an error latches until reset, so it comes last; the kind is drawn
  task automatic test_error_latch();
    int sel;
    sel = $urandom_range(0, 2);
    write_depth(sel == 2 ? 5'd2 : 5'd16);
    if (sel == 0) byte_q.push_back($urandom_range(0, 1) ? B_NEVER : B_FIXEXT1 + $urandom_range(0, 4));
    else if (sel == 1) begin
      byte_q.push_back(8'h81); byte_q.push_back(8'h05);
    end else begin
      byte_q.push_back(8'h91); byte_q.push_back(8'h81);
      byte_q.push_back(8'hA0); byte_q.push_back(B_FIXARR_MIN);
    end
    repeat (60) byte_q.push_back($urandom_range(0, 255));
    flush_bytes();
  endtask

  // ---------------- receiver and checking

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) stall_left <= steady ? 0 : $urandom_range(0, 13);
    else if (stall_left > 0) stall_left <= stall_left - 1;
    out_stall_i <= !(out_valid_o && !out_stall_i) && stall_left > 1;
  end

  always @(posedge clk_i) begin
    token_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        $display("%0t: token with none expected: kind %0d value %h", $time,
                 token_kind_o, token_value_o);
        failures++;
      end else begin
        e = token_q.pop_front();
        if (token_kind_o !== e.kind || token_value_o !== e.value ||
            nesting_depth_o !== e.depth || is_map_key_o !== e.key ||
            value_complete_o !== e.done || error_code_o !== e.code) begin
          $display("%0t: token mismatch exp kind %0d value %h depth %0d key %b done %b err %0d",
                   $time, e.kind, e.value, e.depth, e.key, e.done, e.code);
          $display("%0t:                got kind %0d value %h depth %0d key %b done %b err %0d",
                   $time, token_kind_o, token_value_o, nesting_depth_o, is_map_key_o,
                   value_complete_o, error_code_o);
          failures++;
        end
      end
    end
  end

  initial begin
    phase = PH_TYPE; field_left = 0; field_acc = '0; field_kind = K_NIL;
    bytes_left = '0; depth_ptr = 0; err_held = '0; depth_limit = 5'd16;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_values();
    test_depth_settings();
    test_pause();
    test_error_latch();
    drain();
    if (failures == 0 && token_q.size() == 0) $display("msgpack_stream_tokenizer_top_test passed");
    else begin
      if (token_q.size() > 0) $display("%0t: %0d tokens never arrived", $time, token_q.size());
      $display("msgpack_stream_tokenizer_top_test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("msgpack_stream_tokenizer_top_test failed");
    $finish;
  end

endmodule
